FILE: hw/rtl/interval_jitter_histogram_assert.svh
// Assertion macros for the interval jitter histogram.
// Used by the top level only; no other dependencies.
`ifndef INTERVAL_JITTER_HISTOGRAM_ASSERT_SVH
`define INTERVAL_JITTER_HISTOGRAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IJH_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// The condition must never be observed outside reset.
`define IJH_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition observed");

`endif

FILE: hw/rtl/ijh_pkg.sv
// Shared constants, types and codes of the interval jitter histogram.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package ijh_pkg;

   localparam int NUM_BINS    = 100;
   localparam int COUNT_WIDTH = 17;
   localparam int BIN_WIDTH   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int LAST_BIN    = NUM_BINS - 1;

   // Fixed widths of the transaction fields.
   localparam int SEC_WIDTH      = 32;
   localparam int NS_WIDTH       = 30;
   localparam int RBIN_WIDTH     = 7;
   localparam int OUT_CNT_WIDTH  = 17;

   localparam int NS_PER_SEC  = 1000000000;
   localparam int NS_PER_BIN  = 10000;
   localparam int SPAN_NS     = NUM_BINS * NS_PER_BIN;
   localparam int SMALL_WIDTH = $clog2(SPAN_NS);

   // Division by NS_PER_BIN is a multiply by its rounded-up reciprocal scaled by 2^DIV_SHIFT.
   localparam int DIV_SHIFT = 34;
   localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + NS_PER_BIN - 1) / NS_PER_BIN;
   localparam int PROD_WIDTH  = DIV_SHIFT + BIN_WIDTH + 1;

   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_COUNT,
      KIND_READ
   } kind_type;

   typedef struct packed {
      logic                   valid;
      kind_type               kind;
      logic [BIN_WIDTH-1:0]   bin;
      logic [RBIN_WIDTH-1:0]  read_bin;
   } item_type;

   typedef struct packed {
      logic                      counted;
      logic [RBIN_WIDTH-1:0]     bin_number;
      logic [OUT_CNT_WIDTH-1:0]  bin_count;
   } result_type;

endpackage

FILE: hw/rtl/ijh_if.sv
// Request and response channel interfaces of the interval jitter histogram.
// Depends on ijh_pkg for the field widths.
interface ijh_req_if;
   logic                              valid;
   logic                              ready;
   logic                              command;
   logic [ijh_pkg::SEC_WIDTH-1:0]     stamp_seconds;
   logic [ijh_pkg::NS_WIDTH-1:0]      stamp_nanoseconds;
   logic [ijh_pkg::RBIN_WIDTH-1:0]    read_bin;

   modport source (output valid, command, stamp_seconds, stamp_nanoseconds, read_bin,
                   input ready);
   modport sink   (input valid, command, stamp_seconds, stamp_nanoseconds, read_bin,
                   output ready);
endinterface

interface ijh_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               counted;
   logic [ijh_pkg::RBIN_WIDTH-1:0]     bin_number;
   logic [ijh_pkg::OUT_CNT_WIDTH-1:0]  bin_count;

   modport source (output valid, counted, bin_number, bin_count, input ready);
   modport sink   (input valid, counted, bin_number, bin_count, output ready);
endinterface

FILE: hw/rtl/ijh_interval.sv
// Interval front end: keeps the reference timestamp, subtracts with a nanosecond
// borrow and maps the interval to a bin over four stages. Depends on ijh_pkg.
module ijh_interval (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               accept,
   input  logic                               command,
   input  logic [ijh_pkg::SEC_WIDTH-1:0]      stamp_seconds,
   input  logic [ijh_pkg::NS_WIDTH-1:0]       stamp_nanoseconds,
   input  logic [ijh_pkg::RBIN_WIDTH-1:0]     read_bin,
   output ijh_pkg::item_type                  item
);

   typedef enum logic [1:0] {
      RANGE_LOW,
      RANGE_MID,
      RANGE_HIGH
   } range_type;

   // Reference timestamp.
   logic [ijh_pkg::SEC_WIDTH-1:0] prev_s_ff;
   logic [ijh_pkg::NS_WIDTH-1:0]  prev_ns_ff;
   logic                          have_ref_ff;

   // Stage 0: captured transaction.
   logic                            s0_valid_ff;
   ijh_pkg::kind_type               s0_kind_ff, s0_kind_in;
   logic [ijh_pkg::SEC_WIDTH-1:0]   s0_now_s_ff, s0_prev_s_ff;
   logic [ijh_pkg::NS_WIDTH-1:0]    s0_now_ns_ff, s0_prev_ns_ff;
   logic [ijh_pkg::RBIN_WIDTH-1:0]  s0_rbin_ff;

   // Stage 1: raw differences.
   logic                            s1_valid_ff;
   ijh_pkg::kind_type               s1_kind_ff;
   logic [ijh_pkg::RBIN_WIDTH-1:0]  s1_rbin_ff;
   logic [ijh_pkg::SEC_WIDTH-1:0]   s1_ds_ff, s1_ds_in;
   logic [ijh_pkg::NS_WIDTH:0]      s1_dns_ff, s1_dns_in;

   // Stage 2: range class and in-range nanoseconds.
   logic                              s2_valid_ff;
   ijh_pkg::kind_type                 s2_kind_ff;
   logic [ijh_pkg::RBIN_WIDTH-1:0]    s2_rbin_ff;
   range_type                         s2_range_ff, s2_range_in;
   logic [ijh_pkg::SMALL_WIDTH-1:0]   s2_small_ff;

   // Stage 3: reciprocal product.
   logic                              s3_valid_ff;
   ijh_pkg::kind_type                 s3_kind_ff;
   logic [ijh_pkg::RBIN_WIDTH-1:0]    s3_rbin_ff;
   range_type                         s3_range_ff;
   logic [ijh_pkg::PROD_WIDTH-1:0]    s3_prod_ff, s3_prod_in;

   logic                              borrow, sec_neg, sec_pos, ns_neg, ns_big;
   logic [ijh_pkg::SEC_WIDTH-1:0]     ns_adj;
   logic [ijh_pkg::BIN_WIDTH-1:0]     quotient;

   always_comb begin
      if (command == ijh_pkg::CMD_READ) begin
         s0_kind_in = ijh_pkg::KIND_READ;
      end else if (!have_ref_ff) begin
         s0_kind_in = ijh_pkg::KIND_FIRST;
      end else begin
         s0_kind_in = ijh_pkg::KIND_COUNT;
      end
   end

   assign s1_ds_in  = s0_now_s_ff - s0_prev_s_ff;
   assign s1_dns_in = {1'b0, s0_now_ns_ff} - {1'b0, s0_prev_ns_ff};

   // A negative nanosecond difference borrows one second.
   assign borrow  = s1_dns_ff[ijh_pkg::NS_WIDTH];
   assign sec_neg = s1_ds_ff[ijh_pkg::SEC_WIDTH-1] || ((s1_ds_ff == '0) && borrow);
   assign sec_pos = !s1_ds_ff[ijh_pkg::SEC_WIDTH-1] && (s1_ds_ff != '0)
                    && !((s1_ds_ff == ijh_pkg::SEC_WIDTH'(1)) && borrow);
   assign ns_adj  = {{(ijh_pkg::SEC_WIDTH - ijh_pkg::NS_WIDTH - 1){s1_dns_ff[ijh_pkg::NS_WIDTH]}},
                     s1_dns_ff}
                    + (borrow ? ijh_pkg::SEC_WIDTH'(ijh_pkg::NS_PER_SEC) : '0);
   assign ns_neg  = ns_adj[ijh_pkg::SEC_WIDTH-1];
   assign ns_big  = ns_adj >= ijh_pkg::SEC_WIDTH'(ijh_pkg::SPAN_NS);

   always_comb begin
      if (sec_neg) begin
         s2_range_in = RANGE_LOW;
      end else if (sec_pos) begin
         s2_range_in = RANGE_HIGH;
      end else if (ns_neg) begin
         s2_range_in = RANGE_LOW;
      end else if (ns_big) begin
         s2_range_in = RANGE_HIGH;
      end else begin
         s2_range_in = RANGE_MID;
      end
   end

   assign s3_prod_in = ijh_pkg::PROD_WIDTH'(s2_small_ff)
                       * ijh_pkg::PROD_WIDTH'(ijh_pkg::DIV_RECIP);
   assign quotient   = s3_prod_ff[ijh_pkg::DIV_SHIFT +: ijh_pkg::BIN_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ref_ff <= 1'b0;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (accept && (command == ijh_pkg::CMD_EVENT)) begin
            have_ref_ff <= 1'b1;
         end
         if (adv) begin
            s0_valid_ff <= accept;
            s1_valid_ff <= s0_valid_ff;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // The reference is cleared with the rest of the state so the first
   // difference after reset is well defined.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_s_ff  <= '0;
         prev_ns_ff <= '0;
      end else if (accept && (command == ijh_pkg::CMD_EVENT)) begin
         prev_s_ff  <= stamp_seconds;
         prev_ns_ff <= stamp_nanoseconds;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_kind_ff    <= s0_kind_in;
         s0_now_s_ff   <= stamp_seconds;
         s0_now_ns_ff  <= stamp_nanoseconds;
         s0_prev_s_ff  <= prev_s_ff;
         s0_prev_ns_ff <= prev_ns_ff;
         s0_rbin_ff    <= read_bin;

         s1_kind_ff    <= s0_kind_ff;
         s1_rbin_ff    <= s0_rbin_ff;
         s1_ds_ff      <= s1_ds_in;
         s1_dns_ff     <= s1_dns_in;

         s2_kind_ff    <= s1_kind_ff;
         s2_rbin_ff    <= s1_rbin_ff;
         s2_range_ff   <= s2_range_in;
         s2_small_ff   <= ns_adj[ijh_pkg::SMALL_WIDTH-1:0];

         s3_kind_ff    <= s2_kind_ff;
         s3_rbin_ff    <= s2_rbin_ff;
         s3_range_ff   <= s2_range_ff;
         s3_prod_ff    <= s3_prod_in;
      end
   end

   always_comb begin
      item.valid    = s3_valid_ff;
      item.kind     = s3_kind_ff;
      item.read_bin = s3_rbin_ff;
      unique case (s3_range_ff)
         RANGE_LOW:  item.bin = '0;
         RANGE_HIGH: item.bin = ijh_pkg::BIN_WIDTH'(ijh_pkg::LAST_BIN);
         RANGE_MID:  item.bin = quotient;
         default:    item.bin = '0;
      endcase
   end

endmodule

FILE: hw/rtl/ijh_count_mem.sv
// Bin counter store: one synchronous memory read in one stage and updated in
// the next, with one-deep write forwarding and per-entry valid bits. Uses ijh_pkg.
module ijh_count_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  ijh_pkg::item_type    item,
   output logic                 result_valid,
   output ijh_pkg::result_type  result
);

   logic [ijh_pkg::COUNT_WIDTH-1:0] count_mem [ijh_pkg::NUM_BINS];
   logic [ijh_pkg::NUM_BINS-1:0]    entry_valid_ff;

   logic [ijh_pkg::BIN_WIDTH-1:0]   rd_addr;
   logic                            rd_in_range;

   // Update stage.
   logic                            up_valid_ff;
   ijh_pkg::kind_type               up_kind_ff;
   logic [ijh_pkg::BIN_WIDTH-1:0]   up_addr_ff;
   logic [ijh_pkg::RBIN_WIDTH-1:0]  up_rbin_ff;
   logic                            up_in_range_ff;
   logic [ijh_pkg::COUNT_WIDTH-1:0] rdata_ff;
   logic                            rvalid_ff;

   // Last write, for an update that follows one to the same entry.
   logic                            fwd_valid_ff;
   logic [ijh_pkg::BIN_WIDTH-1:0]   fwd_addr_ff;
   logic [ijh_pkg::COUNT_WIDTH-1:0] fwd_data_ff;

   logic [ijh_pkg::COUNT_WIDTH-1:0] cur_count, next_count;
   logic                            wr_en;

   assign rd_in_range = 32'(item.read_bin) < ijh_pkg::NUM_BINS;
   assign rd_addr     = (item.kind == ijh_pkg::KIND_READ)
                        ? (rd_in_range ? ijh_pkg::BIN_WIDTH'(item.read_bin) : '0)
                        : item.bin;

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == up_addr_ff)) begin
         cur_count = fwd_data_ff;
      end else if (rvalid_ff) begin
         cur_count = rdata_ff;
      end else begin
         cur_count = '0;
      end
   end

   assign next_count = (&cur_count) ? cur_count : cur_count + 1'b1;
   assign wr_en      = adv && up_valid_ff && (up_kind_ff == ijh_pkg::KIND_COUNT);

   always_ff @(posedge clock) begin
      if (adv) begin
         rdata_ff <= count_mem[rd_addr];
         if (wr_en) begin
            count_mem[up_addr_ff] <= next_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         up_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
      end else if (adv) begin
         up_valid_ff  <= item.valid;
         fwd_valid_ff <= wr_en;
         if (wr_en) begin
            entry_valid_ff[up_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         up_kind_ff     <= item.kind;
         up_addr_ff     <= rd_addr;
         up_rbin_ff     <= item.read_bin;
         up_in_range_ff <= rd_in_range;
         rvalid_ff      <= entry_valid_ff[rd_addr];
         fwd_addr_ff    <= up_addr_ff;
         fwd_data_ff    <= next_count;
      end
   end

   assign result_valid = up_valid_ff;

   always_comb begin
      unique case (up_kind_ff)
         ijh_pkg::KIND_COUNT: begin
            result.counted    = 1'b1;
            result.bin_number = ijh_pkg::RBIN_WIDTH'(up_addr_ff);
            result.bin_count  = ijh_pkg::OUT_CNT_WIDTH'(next_count);
         end
         ijh_pkg::KIND_READ: begin
            result.counted    = 1'b0;
            result.bin_number = up_rbin_ff;
            result.bin_count  = up_in_range_ff ? ijh_pkg::OUT_CNT_WIDTH'(cur_count) : '0;
         end
         default: begin
            result.counted    = 1'b0;
            result.bin_number = '0;
            result.bin_count  = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/interval_jitter_histogram.sv
// Interval jitter histogram. Takes one transaction per clock cycle: a timestamp
// event or a bin read. Each event after the first is subtracted from the one
// before it, the interval is divided into 10 us bins and the bin's saturating
// counter is bumped; negative intervals land in bin 0, intervals past the last
// bin or of a second or more land in the last bin. Every transaction returns one
// response through interval stages s0 to s3, the update stage and the output
// register. The rate is one per cycle, set by the bin counter memory, which
// reads in one stage and writes in the next with the previous write forwarded.
// The counters start at zero after reset with no clearing pass; a stalled
// response holds the whole pipeline.
// Depends on ijh_pkg, ijh_if, ijh_interval, ijh_count_mem and the assertion macros.
`include "interval_jitter_histogram_assert.svh"

module interval_jitter_histogram (
   input  logic       clock,
   input  logic       reset,
   ijh_req_if.sink    req_bus,
   ijh_rsp_if.source  rsp_bus
);

   logic                adv;
   logic                accept;
   ijh_pkg::item_type   item;
   logic                up_valid;
   ijh_pkg::result_type up_result;

   logic                rsp_valid_ff;
   ijh_pkg::result_type rsp_data_ff;

   // The pipeline moves whenever the output register is empty or being drained.
   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && adv;
   assign req_bus.ready = adv;

   ijh_interval u_interval (
      .clock             (clock),
      .reset             (reset),
      .adv               (adv),
      .accept            (accept),
      .command           (req_bus.command),
      .stamp_seconds     (req_bus.stamp_seconds),
      .stamp_nanoseconds (req_bus.stamp_nanoseconds),
      .read_bin          (req_bus.read_bin),
      .item              (item)
   );

   ijh_count_mem u_count_mem (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .item         (item),
      .result_valid (up_valid),
      .result       (up_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= up_result;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.counted    = rsp_data_ff.counted;
   assign rsp_bus.bin_number = rsp_data_ff.bin_number;
   assign rsp_bus.bin_count  = rsp_data_ff.bin_count;

   `IJH_ASSERT_IMPLIES(a_stall_blocks_input, clock, reset, rsp_valid_ff && !rsp_bus.ready, !req_bus.ready)
   `IJH_ASSERT_NEVER(a_counted_bin_in_range, clock, reset, rsp_valid_ff && rsp_data_ff.counted && (32'(rsp_data_ff.bin_number) >= ijh_pkg::NUM_BINS))
   `IJH_ASSERT_NEVER(a_bad_read_is_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.counted && (rsp_data_ff.bin_count != '0) && (32'(rsp_data_ff.bin_number) >= ijh_pkg::NUM_BINS))

endmodule
